@@ sv/cisb_pkg.sv @@
// Types, codes and helpers shared by the carrier interrupt and status block.
package cisb_pkg;

  typedef enum logic [1:0] {
    OP_CTRL_READ   = 2'd0,
    OP_CTRL_WRITE  = 2'd1,
    OP_LINE_CHANGE = 2'd2,
    OP_WINDOW_READ = 2'd3
  } op_t;

  // Register indexes of the configuration port
  localparam logic CFG_BIG_ENDIAN = 1'b0;
  localparam logic CFG_PRESENT    = 1'b1;

  // Control window map
  localparam logic [7:0] ADDR_RESET  = 8'h0A;
  localparam logic [7:0] ADDR_STATUS = 8'h0C;

  // The control window map reaches at most four slot control bytes
  localparam int CTRL_SLOTS = 4;
  localparam int TIME_BASE  = 12;

  localparam logic [6:0] OFF_MASK_IO = 7'h7F;
  localparam logic [6:0] OFF_MASK_ID = 7'h3F;

  localparam logic [1:0] SPACE_ID  = 2'd2;
  localparam logic [1:0] SPACE_INT = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd1;
  localparam logic [1:0] SIZE_HALF = 2'd2;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  reg_address;
    logic [9:0]  window_address;
    logic [1:0]  access_size;
    logic [15:0] write_data;
    logic [1:0]  module_index;
    logic        int_line;
    logic        line_level;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        host_irq_level;
    logic        host_irq_pulse;
    logic [7:0]  line_drop_request;
    logic [1:0]  target_slot;
    logic [1:0]  target_space;
    logic [6:0]  target_offset;
    logic        slot_empty;
  } result_t;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

@@ sv/carrier_interrupt_status_block_core.sv @@
// Carrier interrupt and control register block: one item in, one result out.
//
//   channel   signals                           direction  payload
//   item      item_valid / item_stall / item    in         item_t
//   result    result_valid / result_stall / ... out        result_t
//   config    cfg_valid / cfg_ready / cfg_*     in         index, 4-bit data
//
// One item per cycle while item_stall is low; the result goes to the result
// register, or to the skid register if the output stalls. State (slot control,
// status, host flag) updates at the accepting edge. item_stall rises only once
// both result and skid register are full, and it comes straight from a flop.
// Synchronous reset clears the state, configuration and valid flags.
module carrier_interrupt_status_block_core
  import cisb_pkg::*;
#(
  parameter int NUM_SLOTS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  logic [7:0]  slot_control [CTRL_SLOTS];
  logic [7:0]  slot_control_next [CTRL_SLOTS];
  logic [15:0] status_word, status_word_next;
  logic        host_irq_flag, host_irq_flag_next;
  logic [2:0]  big_endian_windows;
  logic [3:0]  module_present_mask;

  logic        skid_valid;
  result_t     skid;
  result_t     res;
  logic        accept;
  logic        out_free;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !skid_valid;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    logic        cswap;
    logic [15:0] v;
    logic [15:0] rd;
    logic [6:0]  ra_half;
    logic [6:0]  cslot_wide;
    logic        cslot_ok;
    logic [1:0]  cslot;
    logic [7:0]  drop;
    logic        pulse;
    logic [7:0]  edge_mask;
    logic [3:0]  bitpos;
    logic [9:0]  wa;
    logic [1:0]  tslot;
    logic [1:0]  tspace;
    logic [6:0]  toff;
    logic        empty;
    logic [2:0]  dpos;

    for (int i = 0; i < CTRL_SLOTS; i++) begin
      slot_control_next[i] = slot_control[i];
    end
    status_word_next   = status_word;
    host_irq_flag_next = host_irq_flag;

    cswap      = big_endian_windows[0] && (item.access_size == SIZE_HALF);
    v          = cswap ? swap16(item.write_data) : item.write_data;
    rd         = '0;
    drop       = '0;
    pulse      = 1'b0;
    tslot      = '0;
    tspace     = '0;
    toff       = '0;
    empty      = 1'b0;
    edge_mask  = '0;
    bitpos     = '0;
    wa         = '0;
    dpos       = '0;

    // Control address 2*s+2 selects slot s; reset and status take precedence
    ra_half    = item.reg_address[7:1];
    cslot_wide = ra_half - 7'd1;
    cslot_ok   = !item.reg_address[0] && (ra_half != 7'd0) &&
                 (item.reg_address != ADDR_RESET) && (item.reg_address != ADDR_STATUS) &&
                 (32'(cslot_wide) < NUM_SLOTS) && (32'(cslot_wide) < CTRL_SLOTS);
    cslot      = cslot_wide[1:0];

    case (item.operation)
      OP_CTRL_READ: begin
        if (cslot_ok) begin
          rd = {8'h00, slot_control[cslot]};
        end else if (item.reg_address == ADDR_STATUS) begin
          rd = status_word;
        end
        if (cswap) begin
          rd = swap16(rd);
        end
      end
      OP_CTRL_WRITE: begin
        if (cslot_ok) begin
          slot_control_next[cslot] = v[7:0];
        end else if (item.reg_address == ADDR_STATUS) begin
          for (int i = 0; i < CTRL_SLOTS; i++) begin
            if (i < NUM_SLOTS) begin
              if (module_present_mask[i]) begin
                drop[2*i +: 2] = v[2*i +: 2];
              end
              if (v[TIME_BASE + i]) begin
                status_word_next[TIME_BASE + i] = 1'b0;
              end
            end
          end
        end
      end
      OP_LINE_CHANGE: begin
        bitpos = {1'b0, item.module_index, item.int_line};
        if ((32'(item.module_index) < NUM_SLOTS) &&
            slot_control[item.module_index][{2'b11, item.int_line}]) begin
          status_word_next[bitpos] = item.line_level;
          if (status_word[bitpos] != item.line_level) begin
            if (slot_control[item.module_index][{2'b10, item.int_line}]) begin
              pulse = item.line_level;
            end else begin
              // Level lines: recompute from status bits, masking out edge lines
              for (int i = 0; i < CTRL_SLOTS; i++) begin
                edge_mask[2*i +: 2] = slot_control[i][5:4];
              end
              host_irq_flag_next = |(status_word_next & {8'h00, ~edge_mask});
            end
          end
        end
      end
      OP_WINDOW_READ: begin
        wa = item.window_address;
        if (big_endian_windows[1] && (item.access_size == SIZE_BYTE)) begin
          wa[0] = ~wa[0];
        end
        tslot  = wa[9:8];
        tspace = wa[7:6];
        toff   = wa[6:0] & ((tspace == SPACE_ID || tspace == SPACE_INT) ?
                            OFF_MASK_ID : OFF_MASK_IO);
        empty  = !((32'(tslot) < NUM_SLOTS) && module_present_mask[tslot]);
        // Interrupt space offsets 0 and 2 acknowledge level lines 0 and 1
        dpos   = {tslot, toff[1]};
        if (!empty && tspace == SPACE_INT && toff[6:2] == 5'd0 && !toff[0]) begin
          if (status_word[{1'b0, dpos}] && !slot_control[tslot][{2'b10, toff[1]}]) begin
            drop[dpos] = 1'b1;
          end
        end
      end
      default: begin
        rd = '0;
      end
    endcase

    res.read_data         = rd;
    res.host_irq_level    = host_irq_flag_next;
    res.host_irq_pulse    = pulse;
    res.line_drop_request = drop;
    res.target_slot       = tslot;
    res.target_space      = tspace;
    res.target_offset     = toff;
    res.slot_empty        = empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CTRL_SLOTS; i++) begin
        slot_control[i] <= '0;
      end
      status_word         <= '0;
      host_irq_flag       <= 1'b0;
      big_endian_windows  <= '0;
      module_present_mask <= '0;
    end else begin
      if (accept) begin
        for (int i = 0; i < CTRL_SLOTS; i++) begin
          slot_control[i] <= slot_control_next[i];
        end
        status_word   <= status_word_next;
        host_irq_flag <= host_irq_flag_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BIG_ENDIAN: big_endian_windows  <= cfg_data[2:0];
          CFG_PRESENT:    module_present_mask <= cfg_data;
          default:        module_present_mask <= module_present_mask;
        endcase
      end
    end
  end

  // Result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end else begin
          result_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result <= skid_valid ? skid : res;
    end
    if (!out_free && accept) begin
      skid <= res;
    end
  end

endmodule
